@@ rtl/core/sem_pkg.sv @@
package sem_pkg;

   localparam int PIX_W        = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int MIN_DIM      = 3;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int OPQ_DEPTH    = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_W'(1);

   localparam logic [PIX_W-1:0] PIX_MAX = '1;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             drain;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_res;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic emit;
      logic border;
      logic last;
   } op_flags_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_UPDATE,
      BK_GRAD,
      BK_SQUARE,
      BK_ROOT,
      BK_EMIT
   } back_state_type;

endpackage

@@ rtl/core/sem_queue.sv @@
module sem_queue
   import sem_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             room,
   input  logic             pop,
   output logic             avail,
   output logic [WIDTH-1:0] head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign room    = count_ff != CNT_W'(DEPTH);
   assign avail   = count_ff != '0;
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push & room;
   assign do_pop  = pop & avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/sem_front.sv @@
module sem_front
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  req_type                       req_data,
   output logic                          req_stall,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          op_room,
   output logic                          op_push,
   output logic [PIX_W-1:0]              op_pixel,
   output logic [$clog2(MAX_WIDTH)-1:0]  op_col,
   output op_flags_type                  op_flags
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int FW_W  = $clog2(MAX_WIDTH + 1);
   localparam int FH_W  = $clog2(MAX_HEIGHT + 1);
   localparam int IR_W  = $clog2(MAX_HEIGHT + 2);
   localparam int OR_W  = $clog2(MAX_HEIGHT);
   localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

   logic [FW_W-1:0]  fw_ff, fw_in, fw_new, fw_last;
   logic [FH_W-1:0]  fh_ff, fh_in, fh_new, fh_last;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [IR_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [OR_W-1:0]  out_row_ff, out_row_in;

   logic [WIDTH_REG_W-1:0]  w_raw;
   logic [HEIGHT_REG_W-1:0] h_raw;
   logic [FW_W-1:0]         col_next, ocol_next;
   logic                    go, frame_done, exec, emit, last, border;

   assign csr_ready = 1'b1;
   assign req_stall = ~op_room;

   assign w_raw = csr_wdata[WIDTH_REG_W-1:0];
   assign h_raw = csr_wdata[HEIGHT_REG_W-1:0];

   always_comb begin
      if (int'(w_raw) > MAX_WIDTH) begin
         fw_new = FW_W'(MAX_WIDTH);
      end else if (int'(w_raw) < MIN_DIM) begin
         fw_new = FW_W'(MIN_DIM);
      end else begin
         fw_new = FW_W'(w_raw);
      end
      if (int'(h_raw) > MAX_HEIGHT) begin
         fh_new = FH_W'(MAX_HEIGHT);
      end else if (int'(h_raw) < MIN_DIM) begin
         fh_new = FH_W'(MIN_DIM);
      end else begin
         fh_new = FH_W'(h_raw);
      end
   end

   assign fw_last    = fw_ff - FW_W'(1);
   assign fh_last    = fh_ff - FH_W'(1);
   assign go         = req_valid & ~req_stall;
   assign frame_done = in_row_ff >= IR_W'(fh_ff);
   assign exec       = go & (frame_done ? req_data.drain : ~req_data.drain);
   assign col_next   = FW_W'(in_col_ff) + FW_W'(1);
   assign ocol_next  = FW_W'(out_col_ff) + FW_W'(1);
   assign emit       = (in_row_ff >= IR_W'(2)) ||
                       ((in_row_ff == IR_W'(1)) && (in_col_ff != '0));
   assign last       = (FH_W'(out_row_ff) == fh_last) && (FW_W'(out_col_ff) == fw_last);
   assign border     = (out_row_ff == '0) || (FH_W'(out_row_ff) >= fh_last) ||
                       (out_col_ff == '0) || (FW_W'(out_col_ff) >= fw_last);

   assign op_push         = exec;
   assign op_pixel        = frame_done ? '0 : req_data.pixel;
   assign op_col          = in_col_ff;
   assign op_flags.emit   = emit;
   assign op_flags.border = border;
   assign op_flags.last   = last;

   always_comb begin
      fw_in      = fw_ff;
      fh_in      = fh_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_valid && (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT)) begin
         if (csr_index == CSR_FRAME_WIDTH) begin
            fw_in = fw_new;
         end else begin
            fh_in = fh_new;
         end
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (exec) begin
         if (col_next >= fw_ff) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IR_W'(1);
         end else begin
            in_col_in = COL_W'(col_next);
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (ocol_next >= fw_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + OR_W'(1);
            end else begin
               out_col_in = COL_W'(ocol_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff      <= FW_W'(RST_W);
         fh_ff      <= FH_W'(RST_H);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         fw_ff      <= fw_in;
         fh_ff      <= fh_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

@@ rtl/core/sem_back.sv @@
module sem_back
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          op_avail,
   output logic                          op_pop,
   input  logic [PIX_W-1:0]              op_pixel,
   input  logic [$clog2(MAX_WIDTH)-1:0]  op_col,
   input  op_flags_type                  op_flags,
   output logic                          rsp_valid,
   output rsp_type                       rsp_data,
   input  logic                          rsp_stall
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int GRAD_W = PIX_W + 3;
   localparam int SQ_W   = 2 * GRAD_W;
   localparam int RAD_W  = 2 * PIX_W;

   back_state_type st_ff, st_in;

   // line store: row above the current one and the one above that
   logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
   logic [PIX_W-1:0] top_mem [MAX_WIDTH];

   logic [PIX_W-1:0]           rd_top_ff, rd_mid_ff;
   logic [PIX_W-1:0]           pixel_ff;
   logic [COL_W-1:0]           col_ff;
   op_flags_type               flags_ff;
   logic [8:0][PIX_W-1:0]      win_ff;
   logic signed [GRAD_W-1:0]   gx_ff, gy_ff, gx_in, gy_in;
   logic signed [SQ_W-1:0]     gx_sq, gy_sq;
   logic [SQ_W-1:0]            sq_sum;
   logic                       sat_ff;
   logic [RAD_W-1:0]           rad_ff;
   logic [PIX_W-1:0]           root_ff, bit_ff, trial;
   logic [RAD_W-1:0]           trial_sq;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff;
   logic                       out_free, take, mem_wr, load_rsp;
   logic [PIX_W-1:0]           res_val;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_IDLE: begin
            if (op_avail) begin
               st_in = BK_UPDATE;
            end
         end
         BK_UPDATE: begin
            if (!flags_ff.emit) begin
               st_in = BK_IDLE;
            end else if (flags_ff.border) begin
               st_in = BK_EMIT;
            end else begin
               st_in = BK_GRAD;
            end
         end
         BK_GRAD: begin
            st_in = BK_SQUARE;
         end
         BK_SQUARE: begin
            st_in = (|sq_sum[SQ_W-1:RAD_W]) ? BK_EMIT : BK_ROOT;
         end
         BK_ROOT: begin
            if (bit_ff[0]) begin
               st_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               st_in = BK_IDLE;
            end
         end
         default: begin
            st_in = BK_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      take     = 1'b0;
      mem_wr   = 1'b0;
      load_rsp = 1'b0;
      case (st_ff)
         BK_IDLE:   take     = op_avail;
         BK_UPDATE: mem_wr   = 1'b1;
         BK_EMIT:   load_rsp = out_free;
         default: begin
            take     = 1'b0;
            mem_wr   = 1'b0;
            load_rsp = 1'b0;
         end
      endcase
   end

   assign op_pop = take;

   always_ff @(posedge clock) begin
      if (take) begin
         rd_top_ff <= top_mem[op_col];
         rd_mid_ff <= mid_mem[op_col];
      end
      if (mem_wr) begin
         top_mem[col_ff] <= rd_mid_ff;
         mid_mem[col_ff] <= pixel_ff;
      end
   end

   always_comb begin
      gx_in = GRAD_W'(win_ff[0]) - GRAD_W'(win_ff[2])
            + (GRAD_W'(win_ff[3]) <<< 1) - (GRAD_W'(win_ff[5]) <<< 1)
            + GRAD_W'(win_ff[6]) - GRAD_W'(win_ff[8]);
      gy_in = GRAD_W'(win_ff[0]) + (GRAD_W'(win_ff[1]) <<< 1) + GRAD_W'(win_ff[2])
            - GRAD_W'(win_ff[6]) - (GRAD_W'(win_ff[7]) <<< 1) - GRAD_W'(win_ff[8]);
   end

   assign gx_sq    = gx_ff * gx_ff;
   assign gy_sq    = gy_ff * gy_ff;
   assign sq_sum   = SQ_W'(unsigned'(gx_sq)) + SQ_W'(unsigned'(gy_sq));
   assign trial    = root_ff | bit_ff;
   assign trial_sq = RAD_W'(trial) * RAD_W'(trial);

   always_comb begin
      if (flags_ff.border) begin
         res_val = win_ff[4];
      end else if (sat_ff) begin
         res_val = PIX_MAX;
      end else begin
         res_val = root_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pixel_ff <= op_pixel;
         col_ff   <= op_col;
         flags_ff <= op_flags;
      end
      if (st_ff == BK_GRAD) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      if (st_ff == BK_SQUARE) begin
         sat_ff  <= |sq_sum[SQ_W-1:RAD_W];
         rad_ff  <= sq_sum[RAD_W-1:0];
         root_ff <= '0;
         bit_ff  <= {1'b1, {(PIX_W - 1){1'b0}}};
      end
      if (st_ff == BK_ROOT) begin
         if (trial_sq <= rad_ff) begin
            root_ff <= trial;
         end
         bit_ff <= bit_ff >> 1;
      end
      if (load_rsp) begin
         rsp_data_ff.edge_res <= res_val;
         rsp_data_ff.last     <= flags_ff.last;
      end
   end

   assign rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_wr) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= rd_top_ff;
            win_ff[3] <= win_ff[4];
            win_ff[4] <= win_ff[5];
            win_ff[5] <= rd_mid_ff;
            win_ff[6] <= win_ff[7];
            win_ff[7] <= win_ff[8];
            win_ff[8] <= pixel_ff;
         end
      end
   end

endmodule

@@ rtl/core/sobel_edge_magnitude_top.sv @@
// Sobel edge magnitude, 3x3 window over a raster pixel stream.
// An item that yields a result passes BK_UPDATE then BK_EMIT on the border; saturated
// ones add BK_GRAD and BK_SQUARE, interior pixels also an 8-step square root in BK_ROOT.
// An item with no result leaves after BK_UPDATE; BK_EMIT waits while a held rsp is stalled;
// the back end takes one item at a time, a 4-entry queue decouples it from req.
// Reset (synchronous, active high) clears counters, window and handshakes; line store is not.
module sobel_edge_magnitude_top
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  req_type                req_data,
   output logic                   req_stall,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   rsp_stall,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int FLAG_W = $bits(op_flags_type);
   localparam int OP_W   = FLAG_W + PIX_W + COL_W;

   logic               q_room, q_push, q_pop, q_avail;
   logic [OP_W-1:0]    q_in, q_head;
   logic [PIX_W-1:0]   f_pixel;
   logic [COL_W-1:0]   f_col;
   op_flags_type       f_flags, b_flags;

   sem_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .op_room   (q_room),
      .op_push   (q_push),
      .op_pixel  (f_pixel),
      .op_col    (f_col),
      .op_flags  (f_flags)
   );

   assign q_in = {f_flags, f_pixel, f_col};

   sem_queue #(
      .WIDTH (OP_W),
      .DEPTH (OPQ_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .room      (q_room),
      .pop       (q_pop),
      .avail     (q_avail),
      .head      (q_head)
   );

   assign b_flags = q_head[OP_W-1 -: FLAG_W];

   sem_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_avail  (q_avail),
      .op_pop    (q_pop),
      .op_pixel  (q_head[COL_W +: PIX_W]),
      .op_col    (q_head[COL_W-1:0]),
      .op_flags  (b_flags),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
